FILE: hdl/scb_pkg.sv
`default_nettype none
package scb_pkg;

	// Access kinds
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Access sizes
	localparam logic [1:0] WID_BYTE = 2'd0;
	localparam logic [1:0] WID_HALF = 2'd1;
	localparam logic [1:0] WID_WORD = 2'd2;

	// Completion status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNALIGNED = 2'd1;
	localparam logic [1:0] ST_FAULT     = 2'd2;

	// Register offsets
	localparam logic [11:0] OFF_CPUID  = 12'h000;
	localparam logic [11:0] OFF_ICSR   = 12'h004;
	localparam logic [11:0] OFF_VTOR   = 12'h008;
	localparam logic [11:0] OFF_AIRCR  = 12'h00C;
	localparam logic [11:0] OFF_SCR    = 12'h010;
	localparam logic [11:0] OFF_CCR    = 12'h014;
	localparam logic [11:0] OFF_PRIO0  = 12'h018;
	localparam logic [11:0] OFF_PRIO1  = 12'h01C;
	localparam logic [11:0] OFF_PRIO2  = 12'h020;
	localparam logic [11:0] OFF_PRIOLS = 12'h023;
	localparam logic [11:0] OFF_SHCSR  = 12'h024;

	// Reset-control write key and the pattern stored in its place
	localparam logic [15:0] KEY_IN     = 16'h05FA;
	localparam logic [15:0] KEY_STORED = 16'hFA05;

	localparam int PRIO_COUNT = 12;

	// Configuration register indexes (word select bit of paddr)
	localparam logic CFG_CPUID = 1'b0;
	localparam logic CFG_CCR   = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [11:0] offset;
		logic [1:0]  access_width;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  status;
	} rsp_t;

endpackage
`default_nettype wire

FILE: hdl/scb_if.sv
`default_nettype none
interface scb_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [11:0] offset;
	logic [1:0]  access_width;
	logic [31:0] write_data;

	modport source (output valid, cmd, offset, access_width, write_data, input ready);
	modport sink (input valid, cmd, offset, access_width, write_data, output ready);
endinterface

interface scb_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [1:0]  status;

	modport source (output valid, read_data, status, input ready);
	modport sink (input valid, read_data, status, output ready);
endinterface
`default_nettype wire

FILE: hdl/scb_cfg.sv
`default_nettype none
module scb_cfg
	import scb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [31:0] cpu_identity,
	output logic      [31:0] config_control
);

	logic [31:0] cpuid_q;
	logic [31:0] ccr_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Only the word select bit decodes; the byte lane bits are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpuid_q <= '0;
			ccr_q   <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				CFG_CPUID: cpuid_q <= pwdata;
				CFG_CCR:   ccr_q   <= pwdata;
				default:   cpuid_q <= cpuid_q;
			endcase
		end
	end

	assign prdata         = (paddr[2] == CFG_CCR) ? ccr_q : cpuid_q;
	assign cpu_identity   = cpuid_q;
	assign config_control = ccr_q;

endmodule
`default_nettype wire

FILE: hdl/scb_regs.sv
`default_nettype none
module scb_regs
	import scb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        upd,
	input  wire req_t        item,
	input  wire logic [31:0] cpu_identity,
	input  wire logic [31:0] config_control,
	output rsp_t             rsp
);

	logic [31:0] icsr_q;
	logic [31:0] vtor_q;
	logic [31:0] aircr_q;
	logic [31:0] scr_q;
	logic [31:0] shcsr_q;
	logic [7:0]  prio_q [PRIO_COUNT];

	logic [31:0] prio_word [3];
	logic [31:0] rd;
	logic [1:0]  st;
	logic        we_icsr, we_vtor, we_aircr, we_scr, we_shcsr;
	logic        we_pbyte, we_pword;
	logic [1:0]  pword_sel;
	logic [3:0]  pbyte_sel;
	logic [11:0] pbyte_diff;

	always_comb begin
		for (int g = 0; g < 3; g++) begin
			prio_word[g] = {prio_q[4*g+3], prio_q[4*g+2], prio_q[4*g+1], prio_q[4*g]};
		end
	end

	assign pbyte_diff = item.offset - OFF_PRIO0;
	assign pbyte_sel  = pbyte_diff[3:0];

	always_comb begin
		rd        = '0;
		st        = ST_OK;
		we_icsr   = 1'b0;
		we_vtor   = 1'b0;
		we_aircr  = 1'b0;
		we_scr    = 1'b0;
		we_shcsr  = 1'b0;
		we_pbyte  = 1'b0;
		we_pword  = 1'b0;
		pword_sel = 2'd0;
		if (item.cmd == CMD_READ) begin
			if (item.access_width != WID_WORD) begin
				st = ST_UNALIGNED;
			end else begin
				unique case (item.offset)
					OFF_CPUID: rd = cpu_identity;
					OFF_ICSR:  rd = icsr_q;
					OFF_VTOR:  rd = vtor_q;
					OFF_AIRCR: rd = aircr_q;
					OFF_SCR:   rd = scr_q;
					OFF_CCR:   rd = config_control;
					OFF_PRIO0: rd = prio_word[0];
					OFF_PRIO1: rd = prio_word[1];
					OFF_PRIO2: rd = prio_word[2];
					OFF_SHCSR: rd = shcsr_q;
					default:   st = ST_FAULT;
				endcase
			end
		end else begin
			priority if (item.access_width == WID_BYTE && item.offset >= OFF_PRIO0
					&& item.offset <= OFF_PRIOLS) begin
				we_pbyte = 1'b1;
			end else if (item.access_width != WID_WORD) begin
				st = ST_UNALIGNED;
			end else begin
				unique case (item.offset)
					OFF_ICSR:  we_icsr = 1'b1;
					OFF_VTOR:  we_vtor = 1'b1;
					OFF_AIRCR: we_aircr = (item.write_data[31:16] == KEY_IN);
					OFF_SCR:   we_scr = 1'b1;
					OFF_PRIO0: begin
						we_pword  = 1'b1;
						pword_sel = 2'd0;
					end
					OFF_PRIO1: begin
						we_pword  = 1'b1;
						pword_sel = 2'd1;
					end
					OFF_PRIO2: begin
						we_pword  = 1'b1;
						pword_sel = 2'd2;
					end
					OFF_SHCSR: we_shcsr = 1'b1;
					default:   st = ST_FAULT;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icsr_q  <= '0;
			vtor_q  <= '0;
			aircr_q <= '0;
			scr_q   <= '0;
			shcsr_q <= '0;
			for (int i = 0; i < PRIO_COUNT; i++) begin
				prio_q[i] <= '0;
			end
		end else if (upd) begin
			if (we_icsr) begin
				icsr_q <= item.write_data;
			end
			if (we_vtor) begin
				vtor_q <= item.write_data;
			end
			if (we_aircr) begin
				aircr_q <= {KEY_STORED, item.write_data[15:0]};
			end
			if (we_scr) begin
				scr_q <= item.write_data;
			end
			if (we_shcsr) begin
				shcsr_q <= item.write_data;
			end
			for (int i = 0; i < PRIO_COUNT; i++) begin
				if (we_pbyte && pbyte_sel == 4'(i)) begin
					prio_q[i] <= item.write_data[7:0];
				end else if (we_pword && pword_sel == 2'(i / 4)) begin
					prio_q[i] <= item.write_data[8*(i%4) +: 8];
				end
			end
		end
	end

	assign rsp.read_data = rd;
	assign rsp.status    = st;

endmodule
`default_nettype wire

FILE: hdl/system_control_register_bank.sv
// Channel  | Role | Payload                                    | Handshake
// req      | sink | cmd, offset, access_width, write_data      | valid / ready
// rsp      | src  | read_data, status                          | valid / ready
// apb cfg  | sink | paddr, pwdata -> prdata                    | psel / penable, pready = 1
//
// An accepted request lands in the stage-one register; the decoder then applies
// any write and forms the response, which is captured in the response register
// when the request advances. Response valid rises as that register is loaded.
// One request is taken every cycle while the response side keeps ready high.
// When the response register is held, the stage-one request waits, and req.ready
// drops only while both are full. Valid flags and bank registers clear to zero on
// arst_n; the stage-one request and response payload registers have no reset.
`default_nettype none
module system_control_register_bank
	import scb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	scb_req_if.sink          req,
	scb_rsp_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [31:0] cpu_identity;
	logic [31:0] config_control;

	// Stage one holds the request; stage two holds the finished response.
	req_t item_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	rsp_t rsp_next;
	logic advance;
	logic take;

	// The stage-one request moves on whenever the response register is free or
	// being emptied this cycle. Its register writes commit on that same edge, so
	// the request behind it always sees the updated state.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd          <= req.cmd;
			item_s1.offset       <= req.offset;
			item_s1.access_width <= req.access_width;
			item_s1.write_data   <= req.write_data;
		end
	end

	scb_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.cpu_identity   (cpu_identity),
		.config_control (config_control)
	);

	scb_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.upd            (advance),
		.item           (item_s1),
		.cpu_identity   (cpu_identity),
		.config_control (config_control),
		.rsp            (rsp_next)
	);

	// The response register empties on a transfer and refills when a request advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.read_data = rsp_s2.read_data;
	assign rsp.status    = rsp_s2.status;

endmodule
`default_nettype wire

FILE: verif/scb_bank_checker.sv
// Watches the request, response and configuration traffic of the system control
// register bank, keeps its own copy of the bank and compares every response.
module scb_bank_checker
	import scb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	scb_req_if          req,
	scb_rsp_if          rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          replies_pending
);

	logic [31:0] cpu_identity;
	logic [31:0] config_control;
	logic [31:0] interrupt_ctrl;
	logic [31:0] vector_base;
	logic [31:0] reset_ctrl;
	logic [31:0] system_ctrl;
	logic [31:0] handler_state;
	logic [7:0]  prio_bytes [PRIO_COUNT];

	rsp_t expected_replies [$];
	req_t seen_req;
	rsp_t want;

	// Applies one access to the local copy of the bank and returns its response.
	function automatic rsp_t bank_access(req_t r);
		rsp_t o;
		int base;
		o.read_data = '0;
		o.status = ST_OK;
		base = int'(r.offset) - int'(OFF_PRIO0);
		if (r.cmd == CMD_READ) begin
			if (r.access_width != WID_WORD) begin
				o.status = ST_UNALIGNED;
			end else begin
				case (r.offset)
					OFF_CPUID: o.read_data = cpu_identity;
					OFF_ICSR:  o.read_data = interrupt_ctrl;
					OFF_VTOR:  o.read_data = vector_base;
					OFF_AIRCR: o.read_data = reset_ctrl;
					OFF_SCR:   o.read_data = system_ctrl;
					OFF_CCR:   o.read_data = config_control;
					OFF_SHCSR: o.read_data = handler_state;
					OFF_PRIO0, OFF_PRIO1, OFF_PRIO2: begin
						for (int k = 0; k < 4; k++)
							o.read_data[8*k +: 8] = prio_bytes[base + k];
					end
					default: o.status = ST_FAULT;
				endcase
			end
		end else begin
			if (r.access_width == WID_BYTE && r.offset >= OFF_PRIO0 && r.offset <= OFF_PRIOLS) begin
				prio_bytes[base] = r.write_data[7:0];
			end else if (r.access_width != WID_WORD) begin
				o.status = ST_UNALIGNED;
			end else begin
				case (r.offset)
					OFF_ICSR:  interrupt_ctrl = r.write_data;
					OFF_VTOR:  vector_base = r.write_data;
					OFF_AIRCR: begin
						if (r.write_data[31:16] == KEY_IN)
							reset_ctrl = {KEY_STORED, r.write_data[15:0]};
					end
					OFF_SCR:   system_ctrl = r.write_data;
					OFF_SHCSR: handler_state = r.write_data;
					OFF_PRIO0, OFF_PRIO1, OFF_PRIO2: begin
						for (int k = 0; k < 4; k++)
							prio_bytes[base + k] = r.write_data[8*k +: 8];
					end
					default: o.status = ST_FAULT;
				endcase
			end
		end
		return o;
	endfunction

	initial begin
		errors = 0;
		replies_pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_identity = '0;
			config_control = '0;
			interrupt_ctrl = '0;
			vector_base = '0;
			reset_ctrl = '0;
			system_ctrl = '0;
			handler_state = '0;
			for (int k = 0; k < PRIO_COUNT; k++)
				prio_bytes[k] = '0;
			expected_replies.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == CFG_CCR)
					config_control = pwdata;
				else
					cpu_identity = pwdata;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_replies.size() == 0) begin
					errors++;
					$display("%0t: unexpected response, expected none, got read_data %h status %0d",
						$time, rsp.read_data, rsp.status);
				end else begin
					want = expected_replies.pop_front();
					if (want.read_data !== rsp.read_data) begin
						errors++;
						$display("%0t: read_data mismatch, expected %h, got %h",
							$time, want.read_data, rsp.read_data);
					end
					if (want.status !== rsp.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp.status);
					end
				end
			end
			if (req.valid && req.ready) begin
				seen_req.cmd = req.cmd;
				seen_req.offset = req.offset;
				seen_req.access_width = req.access_width;
				seen_req.write_data = req.write_data;
				expected_replies.push_back(bank_access(seen_req));
			end
		end
		replies_pending = expected_replies.size();
	end

endmodule

FILE: verif/tb.sv
// Top of the testbench for the system control register bank. It builds the clock
// and reset, drives the request channel and the configuration port, throttles the
// response channel, and gives the verdict. All prediction and comparison live in
// the checker instantiated beside the block.
module tb;
	import scb_pkg::*;

	// An access size code that no legal transfer uses; the bank must call it unaligned.
	localparam logic [1:0] WID_BAD = 2'd3;

	localparam int PHASES = 6;
	localparam int ACCESSES_PER_PHASE = 308;

	// Patterns that the response side cycles through, each for a stretch of cycles.
	typedef enum logic [1:0] {RX_OPEN, RX_SPOTTY, RX_COMB, RX_HELD} rx_mode_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          replies_pending;
	int          burst_left;

	scb_req_if req_ch ();
	scb_rsp_if rsp_ch ();

	system_control_register_bank DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	scb_bank_checker bank_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.errors          (errors),
		.replies_pending (replies_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Writes one configuration register through a setup and an access cycle.
	// Every task below is entered right after a rising edge.
	task automatic cfg_write(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offers one access and returns at the edge where it is transferred. The sender
	// works in bursts; when a burst runs out, valid drops for a random gap. The gap
	// is never empty, so valid never falls and rises in the same step.
	task automatic send_access(input logic cmd, input logic [11:0] off,
			input logic [1:0] wid, input logic [31:0] data);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(20, 60);
			else
				burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.offset <= off;
		req_ch.access_width <= wid;
		req_ch.write_data <= data;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stops offering accesses until every response is back, then lets the
	// pipeline settle a little longer.
	task automatic drain_bank();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (replies_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// One random access. Most go to real registers, the priority bytes or the
	// keyed reset-control word so that state is built up and read back; the rest
	// are noise over the whole offset space and every legal size.
	task automatic random_access();
		int          pick;
		logic        cmd;
		logic [11:0] off;
		logic [1:0]  wid;
		logic [31:0] data;
		pick = $urandom_range(0, 99);
		cmd = 1'($urandom_range(0, 1));
		data = $urandom;
		if ($urandom_range(0, 9) == 0)
			data = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		if (pick < 55) begin
			off = 12'(4 * $urandom_range(0, 9));
			wid = WID_WORD;
		end else if (pick < 70) begin
			off = OFF_PRIO0 + 12'($urandom_range(0, PRIO_COUNT - 1));
			wid = WID_BYTE;
		end else if (pick < 80) begin
			// Reset-control writes, half of them with the right key.
			cmd = CMD_WRITE;
			off = OFF_AIRCR;
			wid = WID_WORD;
			if ($urandom_range(0, 1) == 0)
				data[31:16] = KEY_IN;
		end else begin
			off = 12'($urandom_range(0, 4095));
			wid = 2'($urandom_range(0, 2));
		end
		send_access(cmd, off, wid, data);
	endtask

	// The response side stalls on its own pattern: fully open stretches, random
	// stalls, a sparse comb, and short stretches held low.
	initial begin
		rx_mode_e mode;
		int       stretch;
		rsp_ch.ready <= 1'b0;
		forever begin
			mode = rx_mode_e'($urandom_range(0, 3));
			stretch = (mode == RX_HELD) ? $urandom_range(2, 16) : $urandom_range(10, 80);
			for (int k = 0; k < stretch; k++) begin
				@(posedge clk);
				case (mode)
					RX_OPEN:   rsp_ch.ready <= 1'b1;
					RX_SPOTTY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_COMB:   rsp_ch.ready <= (k % 4 == 3);
					default:   rsp_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [31:0] cpu_val;
		logic [31:0] ccr_val;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_READ;
		req_ch.offset <= '0;
		req_ch.access_width <= WID_WORD;
		req_ch.write_data <= '0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: read-only words, every writable word except the second and third
		// priority words, the reset-control key with and without it, both ways of writing
		// priority bytes, and each fault and unaligned case.
		cfg_write(CFG_CPUID, 32'h410F_C241);
		cfg_write(CFG_CCR, 32'h0000_0200);
		send_access(CMD_READ, OFF_CPUID, WID_WORD, 32'h0);
		send_access(CMD_READ, OFF_CCR, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_WRITE, OFF_ICSR, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_WRITE, OFF_VTOR, WID_WORD, 32'h0);
		send_access(CMD_WRITE, OFF_SCR, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_WRITE, OFF_SHCSR, WID_WORD, 32'hA5A5_5A5A);
		send_access(CMD_WRITE, OFF_AIRCR, WID_WORD, {KEY_IN, 16'h1234});
		// Without the key the write is dropped and the stored word stays.
		send_access(CMD_WRITE, OFF_AIRCR, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_WRITE, OFF_PRIO0, WID_WORD, 32'h80FF_0001);
		send_access(CMD_WRITE, OFF_PRIO0 + 12'd3, WID_BYTE, 32'hFFFF_FF12);
		send_access(CMD_WRITE, OFF_PRIOLS, WID_BYTE, 32'h0000_00FF);
		send_access(CMD_WRITE, OFF_CPUID, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_WRITE, OFF_CCR, WID_WORD, 32'hFFFF_FFFF);
		send_access(CMD_READ, OFF_AIRCR, WID_WORD, 32'h0);
		send_access(CMD_READ, OFF_PRIO0, WID_WORD, 32'h0);
		send_access(CMD_READ, OFF_PRIO1, WID_WORD, 32'h0);
		send_access(CMD_READ, OFF_PRIO2, WID_WORD, 32'h0);
		send_access(CMD_READ, OFF_ICSR, WID_HALF, 32'h0);
		send_access(CMD_READ, OFF_PRIO0, WID_BYTE, 32'h0);
		send_access(CMD_WRITE, OFF_ICSR, WID_HALF, 32'h1234_5678);
		send_access(CMD_WRITE, OFF_PRIO0, WID_BAD, 32'hFFFF_FFFF);
		send_access(CMD_WRITE, OFF_SCR, WID_BYTE, 32'h0000_00FF);
		send_access(CMD_READ, 12'h028, WID_WORD, 32'h0);
		send_access(CMD_READ, 12'hFFF, WID_WORD, 32'h0);
		send_access(CMD_WRITE, 12'h002, WID_WORD, 32'hFFFF_FFFF);

		// Random part in phases. The bank is drained before each configuration
		// change; the first two phases use the extreme identity and control words.
		for (int p = 0; p < PHASES; p++) begin
			drain_bank();
			case (p)
				0: begin
					cpu_val = 32'h0;
					ccr_val = 32'hFFFF_FFFF;
				end
				1: begin
					cpu_val = 32'hFFFF_FFFF;
					ccr_val = 32'h0;
				end
				default: begin
					cpu_val = $urandom;
					ccr_val = $urandom;
				end
			endcase
			cfg_write(CFG_CPUID, cpu_val);
			cfg_write(CFG_CCR, ccr_val);
			for (int n = 0; n < ACCESSES_PER_PHASE; n++) begin
				// Now and then the sender holds off until the bank has answered
				// everything it took.
				if ($urandom_range(0, 199) == 0)
					drain_bank();
				random_access();
			end
		end

		drain_bank();
		if (errors == 0 && replies_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
